// ===== rtl/midpoint_ellipse_rasterizer_macros.svh =====
// Assertion macros shared by the midpoint ellipse rasterizer checkers.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MER_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("midpoint ellipse rasterizer check failed");

// Consequent must hold in the cycle after the antecedent.
`define MER_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("midpoint ellipse rasterizer check failed");

`endif

// ===== rtl/mer_pkg.sv =====
// Shared types, codes and the multiply schedule of the midpoint ellipse rasterizer.
`default_nettype none

package mer_pkg;

	// Request type codes.
	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_ADVANCE = 1'b1;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		DP_NONE   = 4'd0,
		DP_LOAD   = 4'd1,
		DP_MUL    = 4'd2,
		DP_INIT   = 4'd3,
		DP_ADV    = 4'd4,
		DP_SETTLE = 4'd5,
		DP_XFIN   = 4'd6,
		DP_NOPT   = 4'd7,
		DP_OUT    = 4'd8
	} dp_op_t;

	// Operand and destination selection of the shared multiplier.
	typedef enum logic [3:0] {
		M_RX2 = 4'd0,
		M_RY2 = 4'd1,
		M_P   = 4'd2,
		M_U   = 4'd3,
		M_V   = 4'd4,
		M_W   = 4'd5,
		M_U2  = 4'd6,
		M_V2  = 4'd7,
		M_W2  = 4'd8
	} mul_sel_t;

	// Ellipse phase.
	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_R1   = 3'b010,
		PH_R2   = 3'b100
	} phase_t;

	typedef struct packed {
		dp_op_t   op;
		mul_sel_t sel;
	} mer_cmd_t;

	typedef struct packed {
		logic phase_idle;
		logic trans;
	} mer_status_t;

	// Positions in the multiply schedule: start setup, then the region change.
	localparam logic [3:0] SEQ_START_FIRST = 4'd0;
	localparam logic [3:0] SEQ_START_LAST  = 4'd2;
	localparam logic [3:0] SEQ_XFER_FIRST  = 4'd3;
	localparam logic [3:0] SEQ_XFER_LAST   = 4'd8;

	function automatic mul_sel_t seq_sel(input logic [3:0] idx);
		mul_sel_t sel;
		unique case (idx)
			4'd0: sel = M_RX2;
			4'd1: sel = M_RY2;
			4'd2: sel = M_P;
			4'd3: sel = M_U;
			4'd4: sel = M_V;
			4'd5: sel = M_W;
			4'd6: sel = M_U2;
			4'd7: sel = M_V2;
			4'd8: sel = M_W2;
			default: sel = M_RX2;
		endcase
		return sel;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/midpoint_ellipse_rasterizer.sv =====
// Steps: an advance request passes the advance, settle and output states; one that crosses
// into region 2 also runs the region-change multiplies, and a start request first loads,
// multiplies and initialises; an advance while idle goes straight to output. One request
// at a time: the next is taken only once the last result is loaded, which a stall delays.
// Reset: arst_n clears the controller, the result valid flag and the phase to idle;
// an advance after reset reports no point until a start request arrives.
`default_nettype none

module midpoint_ellipse_rasterizer
	import mer_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_ready,
	input  wire logic                         req_type,
	input  wire logic signed [COORD_BITS-1:0] center_x,
	input  wire logic signed [COORD_BITS-1:0] center_y,
	input  wire logic        [COORD_BITS-2:0] radius_x,
	input  wire logic        [COORD_BITS-2:0] radius_y,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output logic signed      [COORD_BITS:0]   point0_x,
	output logic signed      [COORD_BITS:0]   point0_y,
	output logic signed      [COORD_BITS:0]   point1_x,
	output logic signed      [COORD_BITS:0]   point1_y,
	output logic signed      [COORD_BITS:0]   point2_x,
	output logic signed      [COORD_BITS:0]   point2_y,
	output logic signed      [COORD_BITS:0]   point3_x,
	output logic signed      [COORD_BITS:0]   point3_y,
	output logic                              is_last,
	output logic                              no_point
);

	// The controller walks each request through its steps and issues at most one datapath
	// operation per cycle. The datapath holds the ellipse state, the shared multiplier
	// and the result register, and reports back whether the ellipse is idle and whether
	// region 1 has ended.
	mer_cmd_t    cmd;
	mer_status_t status;

	// The four points are mirror images of one offset, so the datapath returns only
	// the two x sums and the two y sums.
	logic signed [COORD_BITS:0] x_plus, x_minus, y_plus, y_minus;

	mer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req_type),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// A start request runs three multiplies (squared radii and rx^2*ry) before the
	// first point. The region change runs six more: the three squares of ry*(2x+1),
	// rx*(y-1) and rx*ry give the region 2 decision value without a wide multiplier.
	mer_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.center_x (center_x),
		.center_y (center_y),
		.radius_x (radius_x),
		.radius_y (radius_y),
		.x_plus   (x_plus),
		.x_minus  (x_minus),
		.y_plus   (y_plus),
		.y_minus  (y_minus),
		.is_last  (is_last),
		.no_point (no_point)
	);

	// Quadrant mapping: point0 (+x,+y), point1 (-x,+y), point2 (+x,-y), point3 (-x,-y).
	assign point0_x = x_plus;
	assign point0_y = y_plus;
	assign point1_x = x_minus;
	assign point1_y = y_plus;
	assign point2_x = x_plus;
	assign point2_y = y_minus;
	assign point3_x = x_minus;
	assign point3_y = y_minus;

endmodule

`default_nettype wire

// ===== rtl/mer_ctrl.sv =====
// Controller state machine of the midpoint ellipse rasterizer.
`default_nettype none

module mer_ctrl
	import mer_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic        req_type,
	output logic             res_valid,
	input  wire logic        res_ready,
	input  wire mer_status_t status,
	output mer_cmd_t         cmd
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_MUL    = 7'b0000010,
		ST_INIT   = 7'b0000100,
		ST_ADV    = 7'b0001000,
		ST_SETTLE = 7'b0010000,
		ST_XFIN   = 7'b0100000,
		ST_FIN    = 7'b1000000
	} state_t;

	state_t     state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic       stepped_q, stepped_d;
	logic       res_valid_q;
	logic       load_out;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		stepped_d = stepped_q;
		load_out  = 1'b0;
		cmd.op    = DP_NONE;
		cmd.sel   = seq_sel(cnt_q);
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_type == REQ_START) begin
						cmd.op    = DP_LOAD;
						cnt_d     = SEQ_START_FIRST;
						stepped_d = 1'b0;
						state_d   = ST_MUL;
					end else if (status.phase_idle) begin
						cmd.op  = DP_NOPT;
						state_d = ST_FIN;
					end else begin
						state_d = ST_ADV;
					end
				end
			end
			ST_MUL: begin
				cmd.op = DP_MUL;
				if (cnt_q == SEQ_START_LAST) begin
					state_d = ST_INIT;
				end else if (cnt_q == SEQ_XFER_LAST) begin
					state_d = ST_XFIN;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			ST_INIT: begin
				cmd.op  = DP_INIT;
				state_d = ST_SETTLE;
			end
			ST_ADV: begin
				cmd.op    = DP_ADV;
				stepped_d = 1'b1;
				state_d   = ST_SETTLE;
			end
			ST_SETTLE: begin
				if (status.trans) begin
					cnt_d   = SEQ_XFER_FIRST;
					state_d = ST_MUL;
				end else begin
					cmd.op  = DP_SETTLE;
					state_d = stepped_q ? ST_FIN : ST_ADV;
				end
			end
			ST_XFIN: begin
				cmd.op  = DP_XFIN;
				state_d = stepped_q ? ST_FIN : ST_ADV;
			end
			ST_FIN: begin
				if (!res_valid_q || res_ready) begin
					cmd.op   = DP_OUT;
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= SEQ_START_FIRST;
			stepped_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			stepped_q <= stepped_d;
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;

endmodule

`default_nettype wire

// ===== rtl/mer_dp.sv =====
// Datapath of the midpoint ellipse rasterizer: shared multiplier and step arithmetic.
`default_nettype none

module mer_dp
	import mer_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire mer_cmd_t                     cmd,
	output mer_status_t                       status,
	input  wire logic signed [COORD_BITS-1:0] center_x,
	input  wire logic signed [COORD_BITS-1:0] center_y,
	input  wire logic        [COORD_BITS-2:0] radius_x,
	input  wire logic        [COORD_BITS-2:0] radius_y,
	output logic signed      [COORD_BITS:0]   x_plus,
	output logic signed      [COORD_BITS:0]   x_minus,
	output logic signed      [COORD_BITS:0]   y_plus,
	output logic signed      [COORD_BITS:0]   y_minus,
	output logic                              is_last,
	output logic                              no_point
);

	localparam int CB = COORD_BITS;
	localparam int RW = CB - 1;
	localparam int OW = CB + 1;
	localparam int MW = 2 * CB;
	localparam int PW = 4 * CB;
	localparam int SW = 3 * CB + 1;
	localparam int DW = 4 * CB + 2;

	// Saved ellipse parameters.
	logic signed [CB-1:0]   cx_q, cy_q;
	logic        [RW-1:0]   rx_q, ry_q;
	logic        [2*RW-1:0] rx2_q, ry2_q;
	// Product scratch registers.
	logic        [PW-1:0]   s0_q, s1_q, s2_q;
	// Algorithm state.
	phase_t                 phase_q;
	logic        [CB-1:0]   ox_q;
	logic signed [OW-1:0]   oy_q;
	logic signed [SW-1:0]   sdx_q, sdy_q;
	logic signed [DW-1:0]   dec_q;
	logic        [CB-1:0]   snap_x_q;
	logic signed [OW-1:0]   snap_y_q;
	logic                   nopt_q;
	// Result payload.
	logic signed [OW-1:0]   xp_q, xm_q, yp_q, ym_q;
	logic                   last_q, nopt_out_q;

	logic        [MW-1:0]   mul_a, mul_b;
	logic        [PW-1:0]   prod;
	logic        [CB:0]     t_val;
	logic signed [OW-1:0]   ym1;
	logic        [CB-1:0]   ymag;
	logic signed [SW-1:0]   two_rx2, two_ry2, sdx_nx, sdy_nx;
	logic signed [DW-1:0]   four_sdx, four_sdy, four_rx2, four_ry2;
	logic signed [DW-1:0]   dec_init, dec_xfer;
	logic signed [OW-1:0]   cx_w, cy_w, sx_w;
	logic                   dec_neg, dec_zero;

	// Multiplier operand selection.
	assign t_val = {ox_q, 1'b1};
	assign ym1   = oy_q - $signed(OW'(1));
	assign ymag  = ym1[OW-1] ? CB'(-ym1) : CB'(ym1);

	always_comb begin
		unique case (cmd.sel)
			M_RX2: begin
				mul_a = MW'(rx_q);
				mul_b = MW'(rx_q);
			end
			M_RY2: begin
				mul_a = MW'(ry_q);
				mul_b = MW'(ry_q);
			end
			M_P: begin
				mul_a = MW'(rx2_q);
				mul_b = MW'(ry_q);
			end
			M_U: begin
				mul_a = MW'(ry_q);
				mul_b = MW'(t_val);
			end
			M_V: begin
				mul_a = MW'(rx_q);
				mul_b = MW'(ymag);
			end
			M_W: begin
				mul_a = MW'(rx_q);
				mul_b = MW'(ry_q);
			end
			M_U2: begin
				mul_a = s0_q[MW-1:0];
				mul_b = s0_q[MW-1:0];
			end
			M_V2: begin
				mul_a = s1_q[MW-1:0];
				mul_b = s1_q[MW-1:0];
			end
			M_W2: begin
				mul_a = s2_q[MW-1:0];
				mul_b = s2_q[MW-1:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Step arithmetic; the decision variable holds four times the real value.
	assign two_rx2  = $signed(SW'({rx2_q, 1'b0}));
	assign two_ry2  = $signed(SW'({ry2_q, 1'b0}));
	assign sdx_nx   = sdx_q + two_ry2;
	assign sdy_nx   = sdy_q - two_rx2;
	assign four_sdx = DW'(sdx_nx) <<< 2;
	assign four_sdy = DW'(sdy_nx) <<< 2;
	assign four_rx2 = $signed(DW'({rx2_q, 2'b00}));
	assign four_ry2 = $signed(DW'({ry2_q, 2'b00}));
	assign dec_neg  = dec_q[DW-1];
	assign dec_zero = (dec_q == '0);
	assign dec_init = four_ry2 - $signed(DW'(s0_q) << 2) + $signed(DW'(rx2_q));
	assign dec_xfer = $signed(DW'(s0_q)) + $signed(DW'(s1_q) << 2)
		- $signed(DW'(s2_q) << 2);

	assign status.phase_idle = (phase_q == PH_IDLE);
	assign status.trans      = (phase_q == PH_R1) && !(sdx_q < sdy_q);

	// Result coordinates from the snapshot of the plotted offset.
	assign cx_w = OW'(cx_q);
	assign cy_w = OW'(cy_q);
	assign sx_w = $signed({1'b0, snap_x_q});

	// Phase and the no-point flag are control state and reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			nopt_q  <= 1'b0;
		end else begin
			unique case (cmd.op)
				DP_INIT: phase_q <= PH_R1;
				DP_ADV: nopt_q <= 1'b0;
				DP_NOPT: nopt_q <= 1'b1;
				DP_SETTLE: begin
					if (phase_q == PH_R2 && oy_q[OW-1]) begin
						phase_q <= PH_IDLE;
					end
				end
				DP_XFIN: phase_q <= oy_q[OW-1] ? PH_IDLE : PH_R2;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_LOAD: begin
				cx_q <= center_x;
				cy_q <= center_y;
				rx_q <= radius_x;
				ry_q <= radius_y;
			end
			DP_MUL: begin
				unique case (cmd.sel)
					M_RX2: rx2_q <= prod[2*RW-1:0];
					M_RY2: ry2_q <= prod[2*RW-1:0];
					M_P, M_U, M_U2: s0_q <= prod;
					M_V, M_V2: s1_q <= prod;
					M_W, M_W2: s2_q <= prod;
					default: ;
				endcase
			end
			DP_INIT: begin
				ox_q  <= '0;
				oy_q  <= $signed(OW'(ry_q));
				sdx_q <= '0;
				sdy_q <= $signed({s0_q[SW-2:0], 1'b0});
				dec_q <= dec_init;
			end
			DP_ADV: begin
				snap_x_q <= ox_q;
				snap_y_q <= oy_q;
				if (phase_q == PH_R1) begin
					ox_q  <= ox_q + 1'b1;
					sdx_q <= sdx_nx;
					if (dec_neg) begin
						dec_q <= dec_q + four_sdx + four_ry2;
					end else begin
						oy_q  <= oy_q - $signed(OW'(1));
						sdy_q <= sdy_nx;
						dec_q <= dec_q + four_sdx - four_sdy + four_ry2;
					end
				end else if (phase_q == PH_R2) begin
					oy_q  <= oy_q - $signed(OW'(1));
					sdy_q <= sdy_nx;
					if (!dec_neg && !dec_zero) begin
						dec_q <= dec_q + four_rx2 - four_sdy;
					end else begin
						ox_q  <= ox_q + 1'b1;
						sdx_q <= sdx_nx;
						dec_q <= dec_q + four_sdx - four_sdy + four_rx2;
					end
				end
			end
			DP_XFIN: dec_q <= dec_xfer;
			DP_OUT: begin
				if (nopt_q) begin
					xp_q <= '0;
					xm_q <= '0;
					yp_q <= '0;
					ym_q <= '0;
				end else begin
					xp_q <= cx_w + sx_w;
					xm_q <= cx_w - sx_w;
					yp_q <= cy_w + snap_y_q;
					ym_q <= cy_w - snap_y_q;
				end
				last_q     <= !nopt_q && (phase_q == PH_IDLE);
				nopt_out_q <= nopt_q;
			end
			default: ;
		endcase
	end

	assign x_plus   = xp_q;
	assign x_minus  = xm_q;
	assign y_plus   = yp_q;
	assign y_minus  = ym_q;
	assign is_last  = last_q;
	assign no_point = nopt_out_q;

endmodule

`default_nettype wire

// ===== rtl/mer_chk.sv =====
// Port-level checker for the midpoint ellipse rasterizer and its bind.
`default_nettype none

`include "midpoint_ellipse_rasterizer_macros.svh"

module mer_chk #(
	parameter int COORD_BITS = 12
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         req_valid,
	input wire logic                         req_ready,
	input wire logic                         req_type,
	input wire logic signed [COORD_BITS-1:0] center_x,
	input wire logic signed [COORD_BITS-1:0] center_y,
	input wire logic        [COORD_BITS-2:0] radius_x,
	input wire logic        [COORD_BITS-2:0] radius_y,
	input wire logic                         res_valid,
	input wire logic                         res_ready,
	input wire logic signed [COORD_BITS:0]   point0_x,
	input wire logic signed [COORD_BITS:0]   point0_y,
	input wire logic signed [COORD_BITS:0]   point1_x,
	input wire logic signed [COORD_BITS:0]   point1_y,
	input wire logic signed [COORD_BITS:0]   point2_x,
	input wire logic signed [COORD_BITS:0]   point2_y,
	input wire logic signed [COORD_BITS:0]   point3_x,
	input wire logic signed [COORD_BITS:0]   point3_y,
	input wire logic                         is_last,
	input wire logic                         no_point
);

	// Requests are worked one at a time, so ready drops after every acceptance.
	`MER_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

	// The four points always mirror one offset about the center.
	`MER_ASSERT_NOW(a_symmetry, res_valid, (point0_x == point2_x) && (point1_x == point3_x) && (point0_y == point1_y) && (point2_y == point3_y))

	// A no-point result carries zero points and never closes an ellipse.
	`MER_ASSERT_NOW(a_no_point_clean, res_valid && no_point, !is_last && (point0_x == 0) && (point0_y == 0) && (point3_x == 0) && (point3_y == 0))

	// A stalled result holds.
	`MER_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(point0_x) && $stable(point3_y) && $stable(is_last) && $stable(no_point))

endmodule

bind midpoint_ellipse_rasterizer mer_chk #(.COORD_BITS(COORD_BITS)) u_mer_chk (.*);

`default_nettype wire

// ===== tb/sv/ellipse_checker.sv =====
// Scoreboard for the midpoint ellipse rasterizer: traces each ellipse and compares every result.
module ellipse_checker
	import mer_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic                         req_ready,
	input  logic                         req_type,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic        [COORD_BITS-2:0] radius_x,
	input  logic        [COORD_BITS-2:0] radius_y,
	input  logic                         res_valid,
	input  logic                         res_ready,
	input  logic        [COORD_BITS:0]   point0_x,
	input  logic        [COORD_BITS:0]   point0_y,
	input  logic        [COORD_BITS:0]   point1_x,
	input  logic        [COORD_BITS:0]   point1_y,
	input  logic        [COORD_BITS:0]   point2_x,
	input  logic        [COORD_BITS:0]   point2_y,
	input  logic        [COORD_BITS:0]   point3_x,
	input  logic        [COORD_BITS:0]   point3_y,
	input  logic                         is_last,
	input  logic                         no_point,
	output int                           fail_count,
	output int                           outstanding
);

	localparam int OW = COORD_BITS + 1;

	typedef struct packed {
		logic [COORD_BITS:0] p0x;
		logic [COORD_BITS:0] p0y;
		logic [COORD_BITS:0] p1x;
		logic [COORD_BITS:0] p1y;
		logic [COORD_BITS:0] p2x;
		logic [COORD_BITS:0] p2y;
		logic [COORD_BITS:0] p3x;
		logic [COORD_BITS:0] p3y;
		logic                last;
		logic                none;
	} point_set_t;

	// Traced ellipse. The decision term is kept at four times its real value and wraps
	// modulo 2^64; its sign is its top bit.
	phase_t      trace_phase;
	longint      off_x;
	longint      off_y;
	longint      grow_x;
	longint      grow_y;
	logic [63:0] decision;
	logic [63:0] rsq_x;
	logic [63:0] rsq_y;
	longint      ctr_x;
	longint      ctr_y;

	point_set_t points_due[$];

	// Leaves region 1 once the slope passes -1 and goes idle once y drops below zero.
	function automatic void settle_phase();
		logic [63:0] tx;
		logic [63:0] ty;
		if (trace_phase == PH_R1 && !(grow_x < grow_y)) begin
			tx = 2 * off_x + 1;
			ty = off_y - 1;
			decision = rsq_y * tx * tx + 4 * rsq_x * ty * ty - 4 * rsq_x * rsq_y;
			trace_phase = PH_R2;
		end
		if (trace_phase == PH_R2 && off_y < 0)
			trace_phase = PH_IDLE;
	endfunction

	function automatic void step_plot();
		case (trace_phase)
		PH_R1: begin
			off_x++;
			grow_x += 2 * rsq_y;
			if (decision[63]) begin
				decision += 4 * grow_x + 4 * rsq_y;
			end else begin
				off_y--;
				grow_y -= 2 * rsq_x;
				decision += 4 * grow_x - 4 * grow_y + 4 * rsq_y;
			end
		end
		PH_R2: begin
			off_y--;
			grow_y -= 2 * rsq_x;
			if (!decision[63] && decision != 0) begin
				decision += 4 * rsq_x - 4 * grow_y;
			end else begin
				off_x++;
				grow_x += 2 * rsq_y;
				decision += 4 * grow_x - 4 * grow_y + 4 * rsq_x;
			end
		end
		default: ;
		endcase
		settle_phase();
	endfunction

	function automatic point_set_t plot_request(
		input logic                         kind,
		input logic signed [COORD_BITS-1:0] cx,
		input logic signed [COORD_BITS-1:0] cy,
		input logic        [COORD_BITS-2:0] rx,
		input logic        [COORD_BITS-2:0] ry
	);
		point_set_t  ps;
		logic [63:0] r_x;
		logic [63:0] r_y;
		ps = '0;
		if (kind == REQ_START) begin
			r_x = 64'(rx);
			r_y = 64'(ry);
			ctr_x = longint'(cx);
			ctr_y = longint'(cy);
			rsq_x = r_x * r_x;
			rsq_y = r_y * r_y;
			off_x = 0;
			off_y = r_y;
			grow_x = 0;
			grow_y = 2 * rsq_x * r_y;
			decision = 4 * rsq_y - 4 * rsq_x * r_y + rsq_x;
			trace_phase = PH_R1;
			settle_phase();
		end else if (trace_phase == PH_IDLE) begin
			ps.none = 1'b1;
			return ps;
		end
		ps.p0x = OW'(ctr_x + off_x);
		ps.p0y = OW'(ctr_y + off_y);
		ps.p1x = OW'(ctr_x - off_x);
		ps.p1y = OW'(ctr_y + off_y);
		ps.p2x = OW'(ctr_x + off_x);
		ps.p2y = OW'(ctr_y - off_y);
		ps.p3x = OW'(ctr_x - off_x);
		ps.p3y = OW'(ctr_y - off_y);
		step_plot();
		ps.last = (trace_phase == PH_IDLE);
		return ps;
	endfunction

	function automatic int differs(input string field, input logic [COORD_BITS:0] want,
			input logic [COORD_BITS:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s expected %0d, got %0d", $time, field, $signed(want), $signed(got));
		return 1;
	endfunction

	// Results are retired before requests are traced; one request is in flight at a time.
	always @(posedge clk or negedge arst_n) begin : track
		point_set_t want;
		int         errs;
		int         delta;
		if (!arst_n) begin
			trace_phase = PH_IDLE;
			off_x = 0;
			off_y = 0;
			grow_x = 0;
			grow_y = 0;
			decision = '0;
			rsq_x = '0;
			rsq_y = '0;
			ctr_x = 0;
			ctr_y = 0;
			points_due.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			errs = 0;
			delta = 0;
			if (res_valid && res_ready) begin
				if (points_due.size() == 0) begin
					$display("%0t: unrequested result, point0 (%0d, %0d) last %0b none %0b",
						$time, $signed(point0_x), $signed(point0_y), is_last, no_point);
					errs = 1;
				end else begin
					want = points_due.pop_front();
					errs += differs("point0_x", want.p0x, point0_x);
					errs += differs("point0_y", want.p0y, point0_y);
					errs += differs("point1_x", want.p1x, point1_x);
					errs += differs("point1_y", want.p1y, point1_y);
					errs += differs("point2_x", want.p2x, point2_x);
					errs += differs("point2_y", want.p2y, point2_y);
					errs += differs("point3_x", want.p3x, point3_x);
					errs += differs("point3_y", want.p3y, point3_y);
					errs += differs("is_last", OW'(want.last), OW'(is_last));
					errs += differs("no_point", OW'(want.none), OW'(no_point));
					delta--;
				end
			end
			if (req_valid && req_ready) begin
				points_due.push_back(plot_request(req_type, center_x, center_y,
					radius_x, radius_y));
				delta++;
			end
			fail_count <= fail_count + errs;
			outstanding <= outstanding + delta;
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the midpoint ellipse rasterizer testbench: clock, reset, request stimulus and verdict.
module tb_top
	import mer_pkg::*;
();

	localparam int CB = 12;
	localparam int RB = CB - 1;
	// The slowest correct run pairs each request with a start that crosses into region 2,
	// the longest sender gap and the longest receiver stall; the limit leaves several
	// times the cycles of a few thousand such requests.
	localparam int CYCLE_LIMIT = 500000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_ready;
	logic                 req_type;
	logic signed [CB-1:0] center_x;
	logic signed [CB-1:0] center_y;
	logic        [CB-2:0] radius_x;
	logic        [CB-2:0] radius_y;
	logic                 res_valid;
	logic                 res_ready;
	logic signed [CB:0]   point0_x;
	logic signed [CB:0]   point0_y;
	logic signed [CB:0]   point1_x;
	logic signed [CB:0]   point1_y;
	logic signed [CB:0]   point2_x;
	logic signed [CB:0]   point2_y;
	logic signed [CB:0]   point3_x;
	logic signed [CB:0]   point3_y;
	logic                 is_last;
	logic                 no_point;

	int fail_count;
	int outstanding;
	int cycle_count = 0;
	int sent = 0;

	// When set, the matching side runs without idle cycles for a while.
	bit src_steady = 1'b0;
	bit sink_steady = 1'b0;

	midpoint_ellipse_rasterizer #(
		.COORD_BITS(CB)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_type (req_type),
		.center_x (center_x),
		.center_y (center_y),
		.radius_x (radius_x),
		.radius_y (radius_y),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.point0_x (point0_x),
		.point0_y (point0_y),
		.point1_x (point1_x),
		.point1_y (point1_y),
		.point2_x (point2_x),
		.point2_y (point2_y),
		.point3_x (point3_x),
		.point3_y (point3_y),
		.is_last  (is_last),
		.no_point (no_point)
	);

	// The checker watches both channels, traces every ellipse on its own and counts
	// mismatches; the top only drives stimulus and reads the counts at the end.
	ellipse_checker #(
		.COORD_BITS(CB)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_type   (req_type),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius_x   (radius_x),
		.radius_y   (radius_y),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.point0_x   (point0_x),
		.point0_y   (point0_y),
		.point1_x   (point1_x),
		.point1_y   (point1_y),
		.point2_x   (point2_x),
		.point2_y   (point2_y),
		.point3_x   (point3_x),
		.point3_y   (point3_y),
		.is_last    (is_last),
		.no_point   (no_point),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// A hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Presents one request and returns at the rising edge that accepts it. The idle gap
	// comes first, so valid is lowered in the same step as the previous acceptance and
	// never touched twice in one step. Ready is looked at on the falling edge, where it
	// already holds the value that the next rising edge will see.
	task automatic send_req(input logic kind, input logic [CB-1:0] cx,
			input logic [CB-1:0] cy, input logic [CB-2:0] rx, input logic [CB-2:0] ry);
		int gap;
		gap = src_steady ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= kind;
		center_x <= cx;
		center_y <= cy;
		radius_x <= rx;
		radius_y <= ry;
		do @(negedge clk); while (!req_ready);
		@(posedge clk);
		sent++;
	endtask

	task automatic start_ellipse(input logic [CB-1:0] cx, input logic [CB-1:0] cy,
			input logic [CB-2:0] rx, input logic [CB-2:0] ry);
		send_req(REQ_START, cx, cy, rx, ry);
	endtask

	// Advance requests carry random values in the fields they do not use.
	task automatic advance_ellipse(input int count);
		repeat (count)
			send_req(REQ_ADVANCE, CB'($urandom), CB'($urandom), RB'($urandom),
				RB'($urandom));
	endtask

	// The receiver draws a stall before each result and otherwise keeps ready high.
	// It switches now and then into a mode with no stalls at all.
	initial begin : result_sink
		int stall;
		res_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				sink_steady = !sink_steady;
			stall = sink_steady ? 0 : $urandom_range(0, 10);
			if (stall != 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(negedge clk); while (!res_valid);
			@(posedge clk);
		end
	end

	initial begin : stimulus
		int pick;
		int size_pick;
		int rx;
		int ry;
		int steps;

		arst_n = 1'b0;
		req_valid = 1'b0;
		req_type = REQ_ADVANCE;
		center_x = '0;
		center_y = '0;
		radius_x = '0;
		radius_y = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. An advance right after reset finds no ellipse and must report
		// no point.
		advance_ellipse(1);
		// Both radii zero: a single point at the center, then the block is idle again,
		// so both advances report no point.
		start_ellipse('0, '0, '0, '0);
		advance_ellipse(2);
		// Extreme center and radii; the following start drops this ellipse while busy.
		start_ellipse(12'sd2047, -12'sd2048, 11'd2047, 11'd2047);
		advance_ellipse(2);
		// Zero horizontal radius: region 1 is skipped and the points walk down the
		// vertical axis. The opposite extreme of the center goes with it.
		start_ellipse(-12'sd2048, 12'sd2047, 11'd0, 11'd3);
		advance_ellipse(5);
		// Zero vertical radius: again region 1 is skipped and only the center remains.
		start_ellipse(12'sd100, -12'sd100, 11'd4, 11'd0);
		advance_ellipse(1);
		// A small full ellipse that crosses from region 1 into region 2, then four
		// advances past its last point.
		start_ellipse(-12'sd5, 12'sd7, 11'd3, 11'd2);
		advance_ellipse(7);

		// Random part. Most of it is whole ellipses with random centers and mostly small
		// radii, so that both regions and the final step come up often. A few use large
		// radii and are cut short by the next start. The rest is stray advances on an
		// idle block and starts that are dropped after a handful of steps.
		while (sent < 1500) begin
			src_steady = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				size_pick = $urandom_range(0, 99);
				if (size_pick < 4) begin
					rx = $urandom_range(0, 120);
					ry = $urandom_range(0, 120);
				end else if (size_pick < 7) begin
					rx = $urandom_range(0, 2047);
					ry = $urandom_range(0, 2047);
				end else begin
					rx = $urandom_range(0, 20);
					ry = $urandom_range(0, 20);
				end
				steps = rx + ry + $urandom_range(0, 3);
				if (size_pick >= 4 && size_pick < 7)
					steps = $urandom_range(0, 24);
				else if ($urandom_range(0, 6) == 0)
					steps = $urandom_range(0, steps);
				start_ellipse(CB'($urandom), CB'($urandom), RB'(rx), RB'(ry));
				advance_ellipse(steps);
			end else if (pick < 90) begin
				advance_ellipse($urandom_range(1, 3));
			end else begin
				start_ellipse(CB'($urandom), CB'($urandom), RB'($urandom_range(0, 2047)),
					RB'($urandom_range(0, 2047)));
				advance_ellipse($urandom_range(0, 4));
			end
		end
		req_valid <= 1'b0;

		// Drain: wait for every traced result, then give the block time to show any
		// result that nobody asked for.
		@(posedge clk);
		do @(negedge clk); while (outstanding != 0);
		repeat (24) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
